/* rtl/apdu_command_case_checker_unit_defines.svh */
// ----------------------------------------------------------------------------
// APDU case checker assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef APDU_COMMAND_CASE_CHECKER_UNIT_DEFINES_SVH
`define APDU_COMMAND_CASE_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define APDU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apdu checker: same-cycle property failed");

// next-cycle implication
`define APDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apdu checker: next-cycle property failed");

`endif

/* rtl/apdu_pkg.sv */
// ----------------------------------------------------------------------------
// APDU case checker package
// Widths, verdict codes and the snapshot passed from capture to judge.
// ----------------------------------------------------------------------------
package apdu_pkg;

  localparam int COUNT_WIDTH = 17;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam int LE_WIDTH = 17;

  localparam logic [7:0] CLA_BAD     = 8'hFF;
  localparam logic [7:0] INS_MASK    = 8'hF0;
  localparam logic [7:0] INS_BAD_A   = 8'h60;
  localparam logic [7:0] INS_BAD_B   = 8'h90;
  localparam logic [7:0] P3_ZERO     = 8'h00;
  localparam logic [LE_WIDTH-1:0] MAX_LE_RESET = 17'h10000;

  // case kinds
  localparam logic [2:0] CASE_NONE = 3'd0;
  localparam logic [2:0] CASE_1    = 3'd1;
  localparam logic [2:0] CASE_2S   = 3'd2;
  localparam logic [2:0] CASE_3S   = 3'd3;
  localparam logic [2:0] CASE_4S   = 3'd4;
  localparam logic [2:0] CASE_2E   = 3'd5;
  localparam logic [2:0] CASE_3E   = 3'd6;
  localparam logic [2:0] CASE_4E   = 3'd7;

  // error codes
  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_SHORT    = 4'd1;
  localparam logic [3:0] ERR_CLA      = 4'd2;
  localparam logic [3:0] ERR_INS      = 4'd3;
  localparam logic [3:0] ERR_LE       = 4'd4;
  localparam logic [3:0] ERR_SHORT_LC = 4'd5;
  localparam logic [3:0] ERR_EXT_LEN  = 4'd6;
  localparam logic [3:0] ERR_LC_ZERO  = 4'd7;
  localparam logic [3:0] ERR_EXT_LC   = 4'd8;

  // command fields as seen at the last byte
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] len;
    logic [7:0]             cur;
    logic [7:0]             prev;
    logic [7:0]             cla;
    logic [7:0]             ins;
    logic [7:0]             p3;
    logic [15:0]            ext;
  } apdu_snap_t;

endpackage

/* rtl/apdu_capture.sv */
// ----------------------------------------------------------------------------
// APDU byte capture
// Counts bytes, captures header fields and holds a snapshot at the last byte.
// ----------------------------------------------------------------------------
module apdu_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  logic               adv,
  output logic               snap_valid,
  output apdu_pkg::apdu_snap_t snap
);
  import apdu_pkg::*;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt, len;
  logic [7:0]  cla_r, cla_nxt, ins_r, ins_nxt, p3_r, p3_nxt, prior_r;
  logic [15:0] ext_r, ext_nxt;
  logic        snap_v_r, snap_v_nxt;
  apdu_snap_t  snap_r;

  always_comb begin
    len       = (count_r < CNT_MAX) ? count_r + COUNT_WIDTH'(1) : CNT_MAX;
    cla_nxt   = cla_r;
    ins_nxt   = ins_r;
    p3_nxt    = p3_r;
    ext_nxt   = ext_r;
    case (count_r)
      COUNT_WIDTH'(0): cla_nxt = data_byte;
      COUNT_WIDTH'(1): ins_nxt = data_byte;
      COUNT_WIDTH'(4): p3_nxt  = data_byte;
      COUNT_WIDTH'(5): ext_nxt = {data_byte, ext_r[7:0]};
      COUNT_WIDTH'(6): ext_nxt = {ext_r[15:8], data_byte};
      default: ;
    endcase
    count_nxt = last ? '0 : len;
    // slot frees when judge takes it; a last beat refills it
    snap_v_nxt = snap_v_r && !adv;
    if (beat && last) begin
      snap_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      if (beat) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      cla_r   <= cla_nxt;
      ins_r   <= ins_nxt;
      p3_r    <= p3_nxt;
      ext_r   <= ext_nxt;
      prior_r <= data_byte;
      if (last) begin
        snap_r <= '{len: len, cur: data_byte, prev: prior_r, cla: cla_nxt,
                    ins: ins_nxt, p3: p3_nxt, ext: ext_nxt};
      end
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

endmodule

/* rtl/apdu_judge.sv */
// ----------------------------------------------------------------------------
// APDU verdict
// Classifies the snapshot and holds the verdict in the output register.
// ----------------------------------------------------------------------------
module apdu_judge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 snap_valid,
  input  apdu_pkg::apdu_snap_t snap,
  input  logic [apdu_pkg::LE_WIDTH-1:0] max_le,
  input  logic                 out_tready,
  output logic                 adv,
  output logic                 out_tvalid,
  output logic                 valid_res,
  output logic [2:0]           case_kind,
  output logic [3:0]           error_code,
  output logic [15:0]          le_value
);
  import apdu_pkg::*;

  logic                   out_v_r;
  logic [2:0]             kind_r, kind_nxt;
  logic [3:0]             err_r, err_nxt;
  logic [15:0]            le_r, le_nxt, le_raw;
  logic [7:0]             ins_hi;
  logic                   has_le;
  logic [COUNT_WIDTH-1:0] len_s3, len_s4, len_e3, len_e4;

  always_comb begin
    ins_hi = snap.ins & INS_MASK;
    len_s3 = COUNT_WIDTH'(5) + COUNT_WIDTH'(snap.p3);
    len_s4 = COUNT_WIDTH'(6) + COUNT_WIDTH'(snap.p3);
    len_e3 = COUNT_WIDTH'(7) + COUNT_WIDTH'(snap.ext);
    len_e4 = COUNT_WIDTH'(9) + COUNT_WIDTH'(snap.ext);
    kind_nxt = CASE_NONE;
    err_nxt  = ERR_OK;
    le_raw   = '0;
    has_le   = 1'b0;
    if (snap.len < COUNT_WIDTH'(4)) begin
      err_nxt = ERR_SHORT;
    end else if (snap.cla == CLA_BAD) begin
      err_nxt = ERR_CLA;
    end else if (ins_hi == INS_BAD_A || ins_hi == INS_BAD_B) begin
      err_nxt = ERR_INS;
    end else if (snap.len == COUNT_WIDTH'(4)) begin
      kind_nxt = CASE_1;
    end else if (snap.len == COUNT_WIDTH'(5)) begin
      kind_nxt = CASE_2S;
      le_raw   = {8'h00, snap.p3};
      has_le   = 1'b1;
    end else if (snap.p3 != P3_ZERO) begin
      if (snap.len == len_s3) begin
        kind_nxt = CASE_3S;
      end else if (snap.len == len_s4) begin
        kind_nxt = CASE_4S;
        le_raw   = {8'h00, snap.cur};
        has_le   = 1'b1;
      end else begin
        err_nxt = ERR_SHORT_LC;
      end
    end else if (snap.len == COUNT_WIDTH'(7)) begin
      kind_nxt = CASE_2E;
      le_raw   = snap.ext;
      has_le   = 1'b1;
    end else if (snap.len < COUNT_WIDTH'(7)) begin
      err_nxt = ERR_EXT_LEN;
    end else if (snap.ext == 16'h0000) begin
      err_nxt = ERR_LC_ZERO;
    end else if (snap.len == len_e3) begin
      kind_nxt = CASE_3E;
    end else if (snap.len == len_e4) begin
      kind_nxt = CASE_4E;
      le_raw   = {snap.prev, snap.cur};
      has_le   = 1'b1;
    end else begin
      err_nxt = ERR_EXT_LC;
    end
    le_nxt = le_raw;
    // Le above the limit drops the case and the value
    if (has_le && ({1'b0, le_raw} > max_le)) begin
      kind_nxt = CASE_NONE;
      err_nxt  = ERR_LE;
      le_nxt   = '0;
    end
  end

  assign adv = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && snap_valid) begin
      kind_r <= kind_nxt;
      err_r  <= err_nxt;
      le_r   <= le_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign valid_res  = (err_r == ERR_OK);
  assign case_kind  = kind_r;
  assign error_code = err_r;
  assign le_value   = le_r;

endmodule

/* rtl/apdu_command_case_checker_unit.sv */
// ----------------------------------------------------------------------------
// APDU command case checker
// Classifies ISO 7816-4 command APDUs fed one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command byte per beat in in_tdata, in_tlast on the final byte.
//   out_* : one verdict per command, emitted for the in_tlast beat only.
//   cfg_* : write max_le (largest accepted Le); cfg_ready is always high.
//           Write only while no command is in flight.
// Throughput: one byte per cycle, sustained while out_tready is high; a new command
//   may follow its last byte in the next cycle.
// Verdict path: once the last byte is accepted, the verdict reaches out_* through
//   the snapshot register, then the verdict register.
// Reset: byte count and valid flags clear, max_le returns to 65536.
// Stall: while out_tready is low the verdict holds; one more finished command
//   waits in the snapshot register, and while that slot is held in_tready
//   stays low, so no byte is taken until the verdict leaves.
// ----------------------------------------------------------------------------
`include "apdu_command_case_checker_unit_defines.svh"

module apdu_command_case_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] error_code, [19:4] le_value, [23:20] zero
  output logic [3:0]  out_tuser,  // [0] valid_res, [3:1] case_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data    // [16:0] max_le
);
  import apdu_pkg::*;

  logic [LE_WIDTH-1:0] max_le_r;
  logic                adv, snap_valid, beat, valid_res;
  logic [2:0]          case_kind;
  logic [3:0]          error_code;
  logic [15:0]         le_value;
  apdu_snap_t          snap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_le_r <= MAX_LE_RESET;
    end else if (cfg_valid) begin
      max_le_r <= cfg_data;
    end
  end

  // a last beat needs the snapshot slot; hold off whenever it is stuck
  assign in_tready = !snap_valid || adv;
  assign beat      = in_tvalid && in_tready;

  apdu_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .data_byte  (in_tdata),
    .last       (in_tlast),
    .adv        (adv),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  apdu_judge u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .max_le     (max_le_r),
    .out_tready (out_tready),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .valid_res  (valid_res),
    .case_kind  (case_kind),
    .error_code (error_code),
    .le_value   (le_value)
  );

  assign out_tdata = {4'h0, le_value, error_code};
  assign out_tuser = {case_kind, valid_res};

  `APDU_ASSERT_SAME(a_fail_clean, out_tvalid && (error_code != ERR_OK),
                    (case_kind == CASE_NONE) && (le_value == 16'h0000))
  `APDU_ASSERT_SAME(a_ok_has_case, out_tvalid && (error_code == ERR_OK),
                    case_kind != CASE_NONE)
  `APDU_ASSERT_NEXT(a_no_spurious, !snap_valid && !(beat && in_tlast), !snap_valid)
  `APDU_ASSERT_NEXT(a_out_from_snap, !snap_valid && !out_tvalid, !out_tvalid)

endmodule
